// ===== hdl/sgra_pkg.sv =====
// shared constants and types for the serial gamepad report assembler
package sgra_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned BTN_W    = 14;
	localparam int unsigned HAT_W    = 4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [BTN_W-1:0]  btn_t;
	typedef logic [HAT_W-1:0]  hat_t;

	localparam byte_t STICK_NEUTRAL = 8'd128;
	localparam hat_t  HAT_TOP       = 4'd0;
	localparam hat_t  HAT_RIGHT     = 4'd2;
	localparam hat_t  HAT_BOTTOM    = 4'd4;
	localparam hat_t  HAT_LEFT      = 4'd6;
	localparam hat_t  HAT_CENTRE    = 4'd8;

	// command characters
	localparam byte_t CMD_Y       = 8'h59;
	localparam byte_t CMD_B       = 8'h42;
	localparam byte_t CMD_A       = 8'h41;
	localparam byte_t CMD_X       = 8'h58;
	localparam byte_t CMD_L       = 8'h4C;
	localparam byte_t CMD_R       = 8'h52;
	localparam byte_t CMD_ZL      = 8'h5A;
	localparam byte_t CMD_ZR      = 8'h56;
	localparam byte_t CMD_MINUS   = 8'h4D;
	localparam byte_t CMD_PLUS    = 8'h50;
	localparam byte_t CMD_LCLICK  = 8'h55;
	localparam byte_t CMD_RCLICK  = 8'h49;
	localparam byte_t CMD_HOME    = 8'h48;
	localparam byte_t CMD_CAPTURE = 8'h43;
	localparam byte_t CMD_HAT_TOP = 8'h31;
	localparam byte_t CMD_HAT_RT  = 8'h34;
	localparam byte_t CMD_HAT_BOT = 8'h32;
	localparam byte_t CMD_HAT_LT  = 8'h33;
	localparam byte_t CMD_HAT_CTR = 8'h44;
	localparam byte_t CMD_RESET   = 8'h30;

	// one report word
	typedef struct packed {
		btn_t  buttons;
		hat_t  hat;
		byte_t left_x;
		byte_t left_y;
		byte_t right_x;
		byte_t right_y;
	} pad_word_t;

endpackage

// ===== hdl/sgra_ifs.sv =====
// valid/ready channel interfaces for serial bytes and gamepad reports
interface sgra_byte_if
	import sgra_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sgra_report_if
	import sgra_pkg::*;
();
	logic  valid;
	logic  ready;
	btn_t  buttons;
	hat_t  hat;
	byte_t left_x;
	byte_t left_y;
	byte_t right_x;
	byte_t right_y;

	modport source (output valid, output buttons, output hat, output left_x, output left_y,
		output right_x, output right_y, input ready);
	modport sink   (input valid, input buttons, input hat, input left_x, input left_y,
		input right_x, input right_y, output ready);
endinterface

// ===== hdl/serial_gamepad_report_assembler_core.sv =====
// serial gamepad report assembler: parses received bytes into gamepad reports
//
// channels: rx carries one received serial byte per word; report carries one
// assembled gamepad report per word (buttons, hat, four stick bytes)
// a packet is: left-stick flag, optional x/y, right-stick flag, optional
// x/y, count byte, then count command characters
// one report word leaves after the last command byte, or after the count byte
// when the count is zero; all other bytes produce nothing
// the final byte is caught in the input register, then its report lands in the
// report register
// throughput: one byte per cycle unless a report stalls; the only work per byte
// is a small state update between the input register and the report register
// reset: arst_n clears the parse state to waiting for the left-stick flag,
// buttons to zero, hat to centre, sticks to 128, and drops both valids
// stall: a report waiting on report.ready is held stable; bytes that produce
// no report keep flowing, and the input register stops only when it holds a
// report-producing byte that cannot yet move into the report register
module serial_gamepad_report_assembler_core
	import sgra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sgra_byte_if.sink   rx,
	sgra_report_if.source report
);

	// parse phases
	localparam logic [2:0] PH_LFLAG = 3'd0;
	localparam logic [2:0] PH_LX    = 3'd1;
	localparam logic [2:0] PH_LY    = 3'd2;
	localparam logic [2:0] PH_RFLAG = 3'd3;
	localparam logic [2:0] PH_RX    = 3'd4;
	localparam logic [2:0] PH_RY    = 3'd5;
	localparam logic [2:0] PH_COUNT = 3'd6;
	localparam logic [2:0] PH_CMDS  = 3'd7;

	// input register
	logic    valid_s1;
	byte_t   byte_s1;

	// parse state
	logic [2:0] phase_q;
	byte_t      cnt_q;
	btn_t       btn_q;
	hat_t       hat_q;
	byte_t      lx_q, ly_q, rx_q, ry_q;

	// report register
	logic      out_valid_q;
	pad_word_t out_q;

	// next-state values
	logic [2:0] phase_d;
	byte_t      cnt_d;
	btn_t       btn_d;
	hat_t       hat_d;
	byte_t      lx_d, ly_d, rx_d, ry_d;
	logic       emit;

	logic out_free;
	logic adv_s1;

	// report register can take a new word this cycle
	assign out_free = !out_valid_q || report.ready;
	// byte in s1 is consumed unless it needs the report register and it is busy
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign rx.ready = !valid_s1 || adv_s1;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		btn_d   = btn_q;
		hat_d   = hat_q;
		lx_d    = lx_q;
		ly_d    = ly_q;
		rx_d    = rx_q;
		ry_d    = ry_q;
		emit    = 1'b0;
		unique case (phase_q)
			PH_LFLAG: begin
				// packet start clears the report
				btn_d   = '0;
				hat_d   = HAT_CENTRE;
				lx_d    = STICK_NEUTRAL;
				ly_d    = STICK_NEUTRAL;
				rx_d    = STICK_NEUTRAL;
				ry_d    = STICK_NEUTRAL;
				phase_d = (byte_s1 != '0) ? PH_LX : PH_RFLAG;
			end
			PH_LX: begin
				lx_d    = byte_s1;
				phase_d = PH_LY;
			end
			PH_LY: begin
				ly_d    = byte_s1;
				phase_d = PH_RFLAG;
			end
			PH_RFLAG: begin
				phase_d = (byte_s1 != '0) ? PH_RX : PH_COUNT;
			end
			PH_RX: begin
				rx_d    = byte_s1;
				phase_d = PH_RY;
			end
			PH_RY: begin
				ry_d    = byte_s1;
				phase_d = PH_COUNT;
			end
			PH_COUNT: begin
				cnt_d = byte_s1;
				if (byte_s1 == '0) begin
					emit    = 1'b1;
					phase_d = PH_LFLAG;
				end else begin
					phase_d = PH_CMDS;
				end
			end
			PH_CMDS: begin
				case (byte_s1)
					CMD_Y:       btn_d = btn_q | BTN_W'(1 << 0);
					CMD_B:       btn_d = btn_q | BTN_W'(1 << 1);
					CMD_A:       btn_d = btn_q | BTN_W'(1 << 2);
					CMD_X:       btn_d = btn_q | BTN_W'(1 << 3);
					CMD_L:       btn_d = btn_q | BTN_W'(1 << 4);
					CMD_R:       btn_d = btn_q | BTN_W'(1 << 5);
					CMD_ZL:      btn_d = btn_q | BTN_W'(1 << 6);
					CMD_ZR:      btn_d = btn_q | BTN_W'(1 << 7);
					CMD_MINUS:   btn_d = btn_q | BTN_W'(1 << 8);
					CMD_PLUS:    btn_d = btn_q | BTN_W'(1 << 9);
					CMD_LCLICK:  btn_d = btn_q | BTN_W'(1 << 10);
					CMD_RCLICK:  btn_d = btn_q | BTN_W'(1 << 11);
					CMD_HOME:    btn_d = btn_q | BTN_W'(1 << 12);
					CMD_CAPTURE: btn_d = btn_q | BTN_W'(1 << 13);
					CMD_HAT_TOP: hat_d = HAT_TOP;
					CMD_HAT_RT:  hat_d = HAT_RIGHT;
					CMD_HAT_BOT: hat_d = HAT_BOTTOM;
					CMD_HAT_LT:  hat_d = HAT_LEFT;
					CMD_HAT_CTR: hat_d = HAT_CENTRE;
					CMD_RESET: begin
						// hat is left alone on a reset command
						btn_d = '0;
						lx_d  = STICK_NEUTRAL;
						ly_d  = STICK_NEUTRAL;
						rx_d  = STICK_NEUTRAL;
						ry_d  = STICK_NEUTRAL;
					end
					default: ; // unknown characters still count
				endcase
				// count down; last command closes the packet
				if (cnt_q != '0) begin
					cnt_d = cnt_q - 8'd1;
				end
				if (cnt_d == '0) begin
					emit    = 1'b1;
					phase_d = PH_LFLAG;
				end
			end
			default: phase_d = PH_LFLAG;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LFLAG;
			cnt_q   <= '0;
			btn_q   <= '0;
			hat_q   <= HAT_CENTRE;
			lx_q    <= STICK_NEUTRAL;
			ly_q    <= STICK_NEUTRAL;
			rx_q    <= STICK_NEUTRAL;
			ry_q    <= STICK_NEUTRAL;
		end else if (adv_s1) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			btn_q   <= btn_d;
			hat_q   <= hat_d;
			lx_q    <= lx_d;
			ly_q    <= ly_d;
			rx_q    <= rx_d;
			ry_q    <= ry_d;
		end
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && emit) begin
			out_q <= '{buttons: btn_d, hat: hat_d, left_x: lx_d, left_y: ly_d,
				right_x: rx_d, right_y: ry_d};
		end
	end

	assign report.valid   = out_valid_q;
	assign report.buttons = out_q.buttons;
	assign report.hat     = out_q.hat;
	assign report.left_x  = out_q.left_x;
	assign report.left_y  = out_q.left_y;
	assign report.right_x = out_q.right_x;
	assign report.right_y = out_q.right_y;

endmodule

// ===== hdl/sgra_checker.sv =====
// port-level checker for the serial gamepad report assembler, bound to the assembler core
module sgra_checker
	import sgra_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  rx_valid,
	input logic  rx_ready,
	input logic  out_valid,
	input logic  out_ready,
	input btn_t  buttons,
	input hat_t  hat,
	input byte_t left_x
);

	// a report always carries one of the five hat codes
	a_hat_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hat == HAT_TOP || hat == HAT_RIGHT || hat == HAT_BOTTOM ||
			hat == HAT_LEFT || hat == HAT_CENTRE))
		else $error("report hat code out of range");

	// input back-pressure only comes from a stalled report
	a_bp_source: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a stalled report");

	// a fresh report must be preceded by a byte accepted on the input
	a_report_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(rx_valid && rx_ready, 2))
		else $error("report appeared without an accepted byte");

	// a stalled report holds
	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(buttons) && $stable(hat) &&
			$stable(left_x)))
		else $error("stalled report changed");

endmodule

bind serial_gamepad_report_assembler_core sgra_checker u_sgra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx.valid),
	.rx_ready  (rx.ready),
	.out_valid (report.valid),
	.out_ready (report.ready),
	.buttons   (report.buttons),
	.hat       (report.hat),
	.left_x    (report.left_x)
);
